>>> rtl/wbs_pkg.sv
// Package for the windowed bitmap sort block: item types, opcodes and
// configuration register constants. No dependencies.
package wbs_pkg;

    localparam int VALUE_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_SECTION = 1'b0;

    typedef struct packed {
        logic               op;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               valid_res;
    } t_out_item;

endpackage

>>> rtl/windowed_bitmap_sort_top.sv
// Windowed bitmap sort: presence bitmap in one RAM, insert and fetch items.
// Depends on wbs_pkg and wbs_ram.
//
//  port group    dir  handshake            payload
//  in            in   i_in_valid/o_in_stall i_in_data  (t_in_item)
//  out           out  o_out_valid/i_out_stall o_out_data (t_out_item)
//  config        in   psel/penable/pready  paddr, pwdata, prdata
//
// Insert: RAM read, then modify and write back; an out-of-window insert is dropped.
// Fetch: words are read from the cursor (one per cycle) up to the first non-zero
//   word or the last word, then the result moves to the output register.
// After reset a clearing pass writes SECTION_SIZE/WORD_BITS words (512 by
//   default) before the first item is taken; config writes go on meanwhile.
// A stalled result waits in the output register; a further fetch holds
//   its result until that register is free.
module windowed_bitmap_sort_top #(
    parameter int VALUE_RANGE  = 65536,
    parameter int SECTION_SIZE = 32768,
    parameter int WORD_BITS    = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  wbs_pkg::t_in_item                     i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output wbs_pkg::t_out_item                    o_out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wbs_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [wbs_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [wbs_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    import wbs_pkg::*;

    localparam int NUM_WORDS = SECTION_SIZE / WORD_BITS;
    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int CW = ($clog2(SECTION_SIZE) + 2 > VALUE_W + 1) ?
                        $clog2(SECTION_SIZE) + 2 : VALUE_W + 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INS,
        S_SCAN,
        S_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_cursor, n_cursor;
    logic [BW-1:0]   r_bit, n_bit;
    logic            r_section, n_section;
    t_out_item       r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out_data, n_out_data;

    logic                 ram_en, ram_we;
    logic [AW-1:0]        ram_addr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

    logic                 in_accept, cfg_wr;
    logic [CW-1:0]        offset, v_ext, rel, res_sum;
    logic                 in_win;
    logic [AW-1:0]        win_word;
    logic [BW-1:0]        win_bit;
    logic [WORD_BITS-1:0] low_iso;
    logic [BW-1:0]        low_idx;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W-1] == REG_SECTION) ?
                    {{(CFG_DATA_W-1){1'b0}}, r_section} : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

    // window test and word/bit split of an insert value
    assign offset = r_section ? CW'(SECTION_SIZE) : '0;
    assign v_ext = CW'(i_in_data.value);
    assign rel = v_ext - offset;
    assign in_win = (32'(i_in_data.value) < 32'(VALUE_RANGE)) && (v_ext >= offset)
                    && (rel < CW'(SECTION_SIZE));
    assign win_word = AW'(rel >> BW);
    assign win_bit = rel[BW-1:0];

    // lowest set bit of the word just read
    assign low_iso = ram_rdata & (~ram_rdata + WORD_BITS'(1));
    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_iso[i]) low_idx = low_idx | BW'(i);
        end
    end
    assign res_sum = offset + (CW'(r_addr) << BW) + CW'(low_idx);

    always_comb begin
        n_state = r_state;
        n_addr = r_addr;
        n_cursor = r_cursor;
        n_bit = r_bit;
        n_section = r_section;
        n_res = r_res;
        n_out_valid = r_out_valid;
        n_out_data = r_out_data;
        ram_en = 1'b0;
        ram_we = 1'b0;
        ram_addr = r_addr;
        ram_wdata = '0;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_SECTION) n_section = pwdata[0];

        unique case (r_state)
            S_CLEAR: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                if (r_addr == LAST_WORD) begin
                    n_addr = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.op == OP_FETCH) begin
                        ram_en = 1'b1;
                        ram_addr = r_cursor;
                        n_addr = r_cursor;
                        n_state = S_SCAN;
                    end else if (in_win) begin
                        ram_en = 1'b1;
                        ram_addr = win_word;
                        n_addr = win_word;
                        n_bit = win_bit;
                        n_state = S_INS;
                    end
                end
            end
            S_INS: begin
                ram_en = 1'b1;
                ram_we = 1'b1;
                ram_wdata = ram_rdata | (WORD_BITS'(1) << r_bit);
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (ram_rdata != '0) begin
                    ram_en = 1'b1;
                    ram_we = 1'b1;
                    ram_wdata = ram_rdata & ~low_iso;
                    n_cursor = r_addr;
                    n_res.sorted_value = res_sum[VALUE_W-1:0];
                    n_res.valid_res = 1'b1;
                    n_state = S_OUT;
                end else if (r_addr == LAST_WORD) begin
                    n_cursor = '0;
                    n_res.sorted_value = '0;
                    n_res.valid_res = 1'b0;
                    n_state = S_OUT;
                end else begin
                    ram_en = 1'b1;
                    ram_addr = r_addr + AW'(1);
                    n_addr = r_addr + AW'(1);
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data = r_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_cursor <= '0;
            r_section <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_cursor <= n_cursor;
            r_section <= n_section;
            r_out_valid <= n_out_valid;
        end
        r_bit <= n_bit;
        r_res <= n_res;
        r_out_data <= n_out_data;
    end

    wbs_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NUM_WORDS)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // drained scan rewinds the cursor
    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && ram_rdata == '0 && r_addr == LAST_WORD) |=> r_cursor == '0)
        else $error("cursor not rewound after drained scan");

    // scan writes back only a word that held a set bit
    a_scan_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && ram_we) |-> ram_rdata != '0)
        else $error("scan wrote back an empty word");

    // insert always leaves its bit set
    a_ins_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (ram_we && ram_wdata[r_bit]))
        else $error("insert did not set its bit");

    // no memory traffic while a result waits for the output register
    a_out_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !ram_en)
        else $error("RAM access while result pending");

endmodule

>>> rtl/wbs_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module wbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/wbs_checker.sv
// Scoreboard for windowed_bitmap_sort_top: tracks section writes and items on
// both channels, predicts every fetch result and compares it field by field.
// Depends on wbs_pkg.
module wbs_checker #(
    parameter int SECTION_SIZE = 32768,
    parameter int WORD_BITS    = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  wbs_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  wbs_pkg::t_out_item             i_out_data,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [wbs_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [wbs_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import wbs_pkg::*;

    localparam int NUM_WORDS = SECTION_SIZE / WORD_BITS;

    bit [WORD_BITS-1:0] presence [NUM_WORDS];
    int unsigned        cursor;
    bit                 section_sel;
    t_out_item          sorted_q [$];

    function automatic int unsigned window_offset();
        return section_sel ? SECTION_SIZE : 0;
    endfunction

    function automatic void mark_value(logic [VALUE_W-1:0] v);
        int unsigned rel;
        if (v >= window_offset() && v - window_offset() < SECTION_SIZE) begin
            rel = v - window_offset();
            presence[rel / WORD_BITS][rel % WORD_BITS] = 1'b1;
        end
    endfunction

    // lowest set bit from the cursor onward, cleared as it is taken
    function automatic t_out_item take_smallest();
        t_out_item r;
        r = '0;
        for (int w = cursor; w < NUM_WORDS; w++) begin
            if (presence[w] != '0) begin
                for (int b = 0; b < WORD_BITS; b++) begin
                    if (presence[w][b]) begin
                        presence[w][b] = 1'b0;
                        cursor = w;
                        r.sorted_value = VALUE_W'(window_offset() + w * WORD_BITS + b);
                        r.valid_res = 1'b1;
                        return r;
                    end
                end
            end
        end
        cursor = 0;
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            foreach (presence[w]) presence[w] = '0;
            cursor = 0;
            section_sel = 1'b0;
            sorted_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_SECTION)
                section_sel = i_pwdata[0];

            if (i_out_valid && !i_out_stall) begin
                if (sorted_q.size() == 0) begin
                    $display("%0t: result with nothing pending: sorted_value %0d valid_res %0b",
                             $time, i_out_data.sorted_value, i_out_data.valid_res);
                    o_fail_count++;
                end else begin
                    exp_item = sorted_q.pop_front();
                    if (i_out_data.sorted_value !== exp_item.sorted_value) begin
                        $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                                 $time, exp_item.sorted_value, i_out_data.sorted_value);
                        o_fail_count++;
                    end
                    if (i_out_data.valid_res !== exp_item.valid_res) begin
                        $display("%0t: valid_res mismatch: expected %0b, got %0b",
                                 $time, exp_item.valid_res, i_out_data.valid_res);
                        o_fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.op == OP_FETCH)
                    sorted_q.push_back(take_smallest());
                else
                    mark_value(i_in_data.value);
            end
        end
        o_pending = sorted_q.size();
    end

endmodule

>>> tb/testbench.sv
// Top of the windowed bitmap sort testbench: clock, reset, register writes,
// item stimulus and result back-pressure. Depends on wbs_pkg,
// windowed_bitmap_sort_top and wbs_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wbs_pkg::*;

    localparam int   SECTION_SIZE = 32768;
    localparam int   WORD_BITS    = 64;
    localparam int   RANDOM_ITEMS = 1000;
    localparam int   HOLD_CYCLES  = 300;
    localparam int   LIMIT        = 2500000;
    localparam logic REG_SPARE    = ~REG_SECTION;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall;
    t_out_item             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    int                    cycles;
    int                    n_items;
    int                    tx_calm;
    int                    rx_calm;
    bit                    hold_req;
    bit                    cur_section;
    logic [VALUE_W-1:0]    last_v;

    windowed_bitmap_sort_top #(
        .SECTION_SIZE(SECTION_SIZE),
        .WORD_BITS   (WORD_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    wbs_checker #(
        .SECTION_SIZE(SECTION_SIZE),
        .WORD_BITS   (WORD_BITS)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // random wait, with occasional stretches of back-to-back items
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned offset;
        int unsigned r;
        offset = cur_section ? SECTION_SIZE : 0;
        r = $urandom_range(0, 9);
        if (r == 0)
            last_v = VALUE_W'($urandom);
        else if (r > 1 && r < 5)
            last_v = VALUE_W'(offset + $urandom_range(0, 255));
        else if (r >= 5)
            last_v = VALUE_W'(offset + $urandom_range(0, SECTION_SIZE - 1));
        return last_v;
    endfunction

    task automatic send_item(input logic op, input logic [VALUE_W-1:0] v);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data.op <= op;
        in_data.value <= v;
        do @(posedge clk); while (in_stall);
        n_items++;
    endtask

    // drop valid, let every fetch result drain and any insert finish
    task automatic wait_idle();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge clk) penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SECTION)
            cur_section = data[0];
    endtask

    initial begin : result_side
        int w;
        forever begin
            if (hold_req) begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            w = draw_wait(rx_calm);
            if (w > 0) begin
                @(negedge clk) out_stall <= 1'b1;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk) out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : item_side
        int  n;
        bit  first;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        n_items = 0;
        tx_calm = 0;
        rx_calm = 0;
        hold_req = 1'b0;
        cur_section = 1'b0;
        last_v = '0;

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // lower section: empty fetch, edges, out of window, duplicate
        send_item(OP_FETCH, 16'hFFFF);
        send_item(OP_INSERT, 16'd0);
        send_item(OP_INSERT, 16'd32767);
        send_item(OP_INSERT, 16'd32768);
        send_item(OP_INSERT, 16'd65535);
        send_item(OP_INSERT, 16'd63);
        send_item(OP_INSERT, 16'd64);
        send_item(OP_INSERT, 16'd0);
        send_item(OP_INSERT, 16'd1);
        repeat (4) send_item(OP_FETCH, 16'd0);
        // behind the cursor: only found after the rewind
        send_item(OP_INSERT, 16'd5);
        repeat (4) send_item(OP_FETCH, 16'd0);

        wait_idle();
        write_reg(REG_SECTION, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'h0000_0000);
        send_item(OP_INSERT, 16'd32768);
        send_item(OP_INSERT, 16'd65535);
        send_item(OP_INSERT, 16'd32767);
        repeat (2) send_item(OP_FETCH, 16'd0);
        send_item(OP_INSERT, 16'd65000);

        // leftover bit lies behind the cursor, so this fetch reports an invalid result
        wait_idle();
        write_reg(REG_SECTION, 32'h0000_0002);
        send_item(OP_FETCH, 16'd0);

        first = 1'b1;
        while (n_items < 25 + RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 1))
                write_reg(REG_SECTION, $urandom);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, $urandom);
            if (!first && $urandom_range(0, 4) == 0) begin
                repeat (20) send_item(1'($urandom_range(0, 1)), VALUE_W'($urandom));
            end else begin
                n = first ? 16 : $urandom_range(1, 24);
                repeat (n) send_item(OP_INSERT, pick_value());
                if (first)
                    hold_req = 1'b1;
                repeat (n + 2) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item(OP_INSERT, pick_value());
                    else
                        send_item(OP_FETCH, VALUE_W'($urandom));
                end
            end
            first = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/wbs_pkg.sv
rtl/wbs_ram.sv
rtl/windowed_bitmap_sort_top.sv
tb/wbs_checker.sv
tb/testbench.sv
